### sv/mbg_pkg.sv
// Shared types and constants for the maze backtracker generator.
// No dependencies; mbg_pick and maze_backtracker_generator import this package.
package mbg_pkg;

  // Width of the grid side configuration register.
  localparam int GRID_SIDE_W = 5;

  // Request kinds on the input channel; any other code acts as a read.
  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_STEP    = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Wall and neighbour directions, also the bit positions in a wall word.
  localparam logic [1:0] DIR_XM = 2'd0;
  localparam logic [1:0] DIR_YM = 2'd1;
  localparam logic [1:0] DIR_XP = 2'd2;
  localparam logic [1:0] DIR_YP = 2'd3;

  // Wall words: a fresh cell, and the four cells of the central room.
  localparam logic [3:0] WALLS_ALL     = 4'b1111;
  localparam logic [3:0] ROOM_HI_HI    = 4'b1100;
  localparam logic [3:0] ROOM_HI_LO    = 4'b0110;
  localparam logic [3:0] ROOM_LO_HI    = 4'b1001;
  localparam logic [3:0] ROOM_LO_LO    = 4'b0011;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_WR_NB,
    ST_POP_RD,
    ST_RDC,
    ST_OUT
  } state_t;

  // Outcome of the neighbour choice.
  typedef struct packed {
    logic       found;
    logic [1:0] dir;
  } pick_t;

endpackage

### sv/mbg_cell_ram.sv
// Cell store: one entry per cell holding the visited flag and four wall bits.
// One write port and two registered read ports; no package dependency.
module mbg_cell_ram #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [4:0]    wr_data,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [AW-1:0] rd_b_addr,
  output logic [4:0]    rd_a_data,
  output logic [4:0]    rd_b_data
);

  logic [4:0] mem [0:(1 << AW) - 1];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

### sv/mbg_stack_ram.sv
// Backtrack stack store: one packed {y, x} cell address per entry.
// One write port and one registered read port; no package dependency.
module mbg_stack_ram #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data
);

  logic [AW-1:0] mem [0:(1 << AW) - 1];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/mbg_pick.sv
// Neighbour choice: picks candidate (random mod count) among the open neighbours.
// Depends on mbg_pkg for pick_t.
module mbg_pick (
  input  logic [3:0]     open_mask,
  input  logic [15:0]    rnd,
  output mbg_pkg::pick_t pick
);

  import mbg_pkg::*;

  logic [2:0] cnt;
  logic [4:0] digit_sum;
  logic [2:0] fold;
  logic [1:0] mod3;
  logic [1:0] k;

  // Random word modulo three: base-four digits are each congruent to their value.
  always_comb begin
    digit_sum = '0;
    for (int i = 0; i < 8; i++) begin
      digit_sum = digit_sum + 5'(rnd[2*i +: 2]);
    end
    fold = 3'(digit_sum[4]) + 3'(digit_sum[3:2]) + 3'(digit_sum[1:0]);
    if (fold >= 3'd6) begin
      mod3 = 2'(fold - 3'd6);
    end else if (fold >= 3'd3) begin
      mod3 = 2'(fold - 3'd3);
    end else begin
      mod3 = 2'(fold);
    end
  end

  // Index of the chosen candidate for each candidate count.
  always_comb begin
    cnt = 3'($countones(open_mask));
    unique case (cnt)
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3;
      3'd4:    k = rnd[1:0];
      default: k = 2'd0;
    endcase
  end

  // Walk the mask in direction order and stop at the k-th open neighbour.
  always_comb begin
    logic [1:0] seen;
    logic       got;
    seen = '0;
    got  = 1'b0;
    pick.dir = DIR_XM;
    for (int i = 0; i < 4; i++) begin
      if (open_mask[i]) begin
        if (!got && seen == k) begin
          pick.dir = 2'(i);
          got = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
    pick.found = |open_mask;
  end

endmodule

### sv/maze_backtracker_generator.sv
// Maze generator by randomized depth-first search with a backtrack stack.
// Uses mbg_pkg, mbg_cell_ram, mbg_stack_ram and mbg_pick.
//
// Requests arrive on in_valid/in_ready: kind restart, step or read (any other
// code reads). Each request gives exactly one result on out_valid/out_ready.
// cfg_we/cfg_wdata set the grid side, which is taken up at the next restart.
// Cell walls and visited flags live in a two-read, one-write RAM; the path lives
// in a second RAM. The top of the stack is also held in registers.
// A read passes through ST_RDC to ST_OUT. A step reads the four neighbours over
// the two read ports in ST_IDLE and ST_RD1 and picks in ST_RD2; a carve makes
// the two wall writes through the single write port in ST_RD2 and ST_WR_NB, a
// pop reads the new top in ST_RD2 and ST_POP_RD, and a pop to empty goes to
// ST_OUT. A restart sweeps all 2**(2*clog2(MAX_SIDE)) RAM rows (256 at the
// default), writing fresh cells and the central room, and then gives its result.
// After reset a sweep of fresh cells alone runs once with in_ready low and gives
// no result; configuration writes are taken throughout. A stalled receiver holds
// the result in the output register; one further request may be accepted and
// worked on meanwhile, and its result waits until the output register frees.
module maze_backtracker_generator #(
  parameter int MAX_SIDE = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mbg_pkg::GRID_SIDE_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [15:0]                       in_random_value,
  input  logic [3:0]                        in_read_x,
  input  logic [3:0]                        in_read_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [3:0]                        out_cell_x,
  output logic [3:0]                        out_cell_y,
  output logic [3:0]                        out_cell_walls,
  output logic                              out_carved,
  output logic                              out_finished
);

  import mbg_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * CW;
  localparam int DW    = AW + 1;
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam logic [GRID_SIDE_W-1:0] SIDE_RESET =
    (MAX_SIDE < 16) ? GRID_SIDE_W'(MAX_SIDE) : GRID_SIDE_W'(16);

  state_t state_r, state_nxt;

  logic [GRID_SIDE_W-1:0] grid_side_r;
  logic [GRID_SIDE_W-1:0] active_side_r;
  logic [GRID_SIDE_W-1:0] side_clamped;
  logic [DW-1:0]          depth_r;
  logic [CW-1:0]          top_x_r, top_y_r;
  logic [3:0]             top_walls_r;
  logic [15:0]            rnd_r;
  logic [4:0]             nb0_r, nb1_r;
  logic [1:0]             pick_dir_r;
  logic [3:0]             nb_walls_r;
  logic [AW-1:0]          clr_addr_r;
  logic                   room_r;
  logic [3:0]             rx_r, ry_r;
  logic                   rd_in_r;
  logic [3:0]             res_x_r, res_y_r, res_walls_r;
  logic                   res_carved_r, res_finished_r;
  logic                   out_valid_r;
  logic [3:0]             out_x_r, out_y_r, out_walls_r;
  logic                   out_carved_r, out_finished_r;

  logic                   in_acc;
  logic                   out_free;
  logic                   clr_last;
  logic [CW-1:0]          half, half_m1;
  logic [4:0]             clr_data;

  logic                   cw_en, sw_en;
  logic [AW-1:0]          cw_addr, cr_a_addr, cr_b_addr;
  logic [4:0]             cw_data, cr_a_data, cr_b_data;
  logic [AW-1:0]          sw_addr, sw_data, sr_addr, sr_data;

  logic [3:0]             open_mask;
  pick_t                  pick;
  logic [3:0]             chosen_walls;
  logic [1:0]             opp_dir;
  logic [CW-1:0]          nx, ny;
  logic [3:0]             nb_new_walls;

  // Memories.
  mbg_cell_ram #(.AW(AW)) u_cells (
    .clk       (clk),
    .wr_en     (cw_en),
    .wr_addr   (cw_addr),
    .wr_data   (cw_data),
    .rd_a_addr (cr_a_addr),
    .rd_b_addr (cr_b_addr),
    .rd_a_data (cr_a_data),
    .rd_b_data (cr_b_data)
  );

  mbg_stack_ram #(.AW(AW)) u_stack (
    .clk     (clk),
    .wr_en   (sw_en),
    .wr_addr (sw_addr),
    .wr_data (sw_data),
    .rd_addr (sr_addr),
    .rd_data (sr_data)
  );

  mbg_pick u_pick (
    .open_mask (open_mask),
    .rnd       (rnd_r),
    .pick      (pick)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign clr_last = (clr_addr_r == {AW{1'b1}});

  // Grid side clamped to the supported range.
  always_comb begin
    if (grid_side_r < GRID_SIDE_W'(4)) begin
      side_clamped = GRID_SIDE_W'(4);
    end else if (32'(grid_side_r) > MAX_SIDE) begin
      side_clamped = GRID_SIDE_W'(MAX_SIDE);
    end else begin
      side_clamped = grid_side_r;
    end
  end

  // Central room coordinates and the value written to each row by the sweep.
  assign half    = CW'(active_side_r >> 1);
  assign half_m1 = half - 1'b1;

  always_comb begin
    clr_data = {1'b0, WALLS_ALL};
    if (room_r) begin
      if (clr_addr_r == {half, half}) begin
        clr_data = {1'b1, ROOM_HI_HI};
      end else if (clr_addr_r == {half, half_m1}) begin
        clr_data = {1'b1, ROOM_LO_HI};
      end else if (clr_addr_r == {half_m1, half_m1}) begin
        clr_data = {1'b1, ROOM_LO_LO};
      end else if (clr_addr_r == {half_m1, half}) begin
        clr_data = {1'b1, ROOM_HI_LO};
      end
    end
  end

  // Open neighbours: in the grid and not yet visited.
  always_comb begin
    open_mask[DIR_XM] = (top_x_r != '0) && !nb0_r[4];
    open_mask[DIR_YM] = (top_y_r != '0) && !nb1_r[4];
    open_mask[DIR_XP] = ((8'(top_x_r) + 8'd1) < 8'(active_side_r)) && !cr_a_data[4];
    open_mask[DIR_YP] = ((8'(top_y_r) + 8'd1) < 8'(active_side_r)) && !cr_b_data[4];
  end

  // Walls of the chosen neighbour as read, and the carved neighbour afterwards.
  always_comb begin
    unique case (pick.dir)
      DIR_XM:  chosen_walls = nb0_r[3:0];
      DIR_YM:  chosen_walls = nb1_r[3:0];
      DIR_XP:  chosen_walls = cr_a_data[3:0];
      default: chosen_walls = cr_b_data[3:0];
    endcase
  end

  always_comb begin
    nx = top_x_r;
    ny = top_y_r;
    unique case (pick_dir_r)
      DIR_XM:  nx = top_x_r - 1'b1;
      DIR_YM:  ny = top_y_r - 1'b1;
      DIR_XP:  nx = top_x_r + 1'b1;
      default: ny = top_y_r + 1'b1;
    endcase
    opp_dir      = pick_dir_r + 2'd2;
    nb_new_walls = nb_walls_r & ~(4'b0001 << opp_dir);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = room_r ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_RESTART: state_nxt = ST_CLEAR;
            KIND_STEP:    state_nxt = (depth_r == '0) ? ST_OUT : ST_RD1;
            default:      state_nxt = ST_RDC;
          endcase
        end
      end
      ST_RD1: state_nxt = ST_RD2;
      ST_RD2: begin
        if (pick.found) begin
          state_nxt = ST_WR_NB;
        end else begin
          state_nxt = (depth_r == DW'(1)) ? ST_OUT : ST_POP_RD;
        end
      end
      ST_WR_NB:  state_nxt = ST_OUT;
      ST_POP_RD: state_nxt = ST_OUT;
      ST_RDC:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory port controls per state.
  always_comb begin
    cw_en     = 1'b0;
    cw_addr   = '0;
    cw_data   = '0;
    cr_a_addr = '0;
    cr_b_addr = '0;
    sw_en     = 1'b0;
    sw_addr   = '0;
    sw_data   = '0;
    // The stack port always reads the entry below the top.
    sr_addr   = AW'(depth_r - DW'(2));
    unique case (state_r)
      ST_CLEAR: begin
        cw_en   = 1'b1;
        cw_addr = clr_addr_r;
        cw_data = clr_data;
        if (clr_last && room_r) begin
          sw_en   = 1'b1;
          sw_addr = '0;
          sw_data = {half, half};
        end
      end
      ST_IDLE: begin
        if (in_kind == KIND_STEP) begin
          cr_a_addr = {top_y_r, top_x_r - 1'b1};
          cr_b_addr = {top_y_r - 1'b1, top_x_r};
        end else begin
          cr_a_addr = {CW'(in_read_y), CW'(in_read_x)};
        end
      end
      ST_RD1: begin
        cr_a_addr = {top_y_r, top_x_r + 1'b1};
        cr_b_addr = {top_y_r + 1'b1, top_x_r};
      end
      ST_RD2: begin
        if (pick.found) begin
          cw_en   = 1'b1;
          cw_addr = {top_y_r, top_x_r};
          cw_data = {1'b1, top_walls_r & ~(4'b0001 << pick.dir)};
        end else begin
          cr_a_addr = sr_data;
        end
      end
      ST_WR_NB: begin
        cw_en   = 1'b1;
        cw_addr = {ny, nx};
        cw_data = {1'b1, nb_new_walls};
        sw_en   = (32'(depth_r) < CELLS);
        sw_addr = depth_r[AW-1:0];
        sw_data = {ny, nx};
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, configuration and stack control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      grid_side_r   <= GRID_SIDE_W'(16);
      active_side_r <= SIDE_RESET;
      depth_r       <= '0;
      clr_addr_r    <= '0;
      room_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        grid_side_r <= cfg_wdata;
      end
      // Sweep address counter.
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      // Restart latches the side and empties the stack; the sweep pushes the centre.
      if (in_acc && in_kind == KIND_RESTART) begin
        active_side_r <= side_clamped;
        depth_r       <= '0;
        clr_addr_r    <= '0;
        room_r        <= 1'b1;
      end
      if (state_r == ST_CLEAR && clr_last && room_r) begin
        depth_r <= DW'(1);
      end
      if (state_r == ST_RD2 && !pick.found) begin
        depth_r <= depth_r - 1'b1;
      end
      if (state_r == ST_WR_NB && 32'(depth_r) < CELLS) begin
        depth_r <= depth_r + 1'b1;
      end
      // Output register handshake.
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: stack top copy, read captures and the pending result.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last && room_r) begin
          top_x_r        <= half;
          top_y_r        <= half;
          top_walls_r    <= ROOM_HI_HI;
          res_x_r        <= 4'(half);
          res_y_r        <= 4'(half);
          res_walls_r    <= ROOM_HI_HI;
          res_carved_r   <= 1'b0;
          res_finished_r <= 1'b0;
        end
      end
      ST_IDLE: begin
        rnd_r   <= in_random_value;
        rx_r    <= in_read_x;
        ry_r    <= in_read_y;
        rd_in_r <= (8'(in_read_x) < 8'(active_side_r)) &&
                   (8'(in_read_y) < 8'(active_side_r));
        // A step on an empty stack answers at once.
        res_x_r        <= '0;
        res_y_r        <= '0;
        res_walls_r    <= '0;
        res_carved_r   <= 1'b0;
        res_finished_r <= 1'b1;
      end
      ST_RD1: begin
        nb0_r <= cr_a_data;
        nb1_r <= cr_b_data;
      end
      ST_RD2: begin
        pick_dir_r <= pick.dir;
        nb_walls_r <= chosen_walls;
        // Popping to an empty stack reports zeros and finished.
        res_x_r        <= '0;
        res_y_r        <= '0;
        res_walls_r    <= '0;
        res_carved_r   <= 1'b0;
        res_finished_r <= 1'b1;
      end
      ST_WR_NB: begin
        top_x_r        <= nx;
        top_y_r        <= ny;
        top_walls_r    <= nb_new_walls;
        res_x_r        <= 4'(nx);
        res_y_r        <= 4'(ny);
        res_walls_r    <= nb_new_walls;
        res_carved_r   <= 1'b1;
        res_finished_r <= 1'b0;
      end
      ST_POP_RD: begin
        top_x_r        <= sr_data[CW-1:0];
        top_y_r        <= sr_data[AW-1:CW];
        top_walls_r    <= cr_a_data[3:0];
        res_x_r        <= 4'(sr_data[CW-1:0]);
        res_y_r        <= 4'(sr_data[AW-1:CW]);
        res_walls_r    <= cr_a_data[3:0];
        res_carved_r   <= 1'b0;
        res_finished_r <= 1'b0;
      end
      ST_RDC: begin
        res_x_r        <= rx_r;
        res_y_r        <= ry_r;
        res_walls_r    <= rd_in_r ? cr_a_data[3:0] : WALLS_ALL;
        res_carved_r   <= 1'b0;
        res_finished_r <= (depth_r == '0);
      end
      ST_OUT: begin
        if (out_free) begin
          out_x_r        <= res_x_r;
          out_y_r        <= res_y_r;
          out_walls_r    <= res_walls_r;
          out_carved_r   <= res_carved_r;
          out_finished_r <= res_finished_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_cell_x     = out_x_r;
  assign out_cell_y     = out_y_r;
  assign out_cell_walls = out_walls_r;
  assign out_carved     = out_carved_r;
  assign out_finished   = out_finished_r;

endmodule
